FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/swt_pkg.sv
// Package of the sparse weight truncation core: field layout, codes, helpers.
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

	// field widths
	localparam int POS_W  = 6;
	localparam int WGT_W  = 32;
	localparam int DEN_W  = 32;
	localparam int KEEP_W = 7;
	localparam int FLR_W  = 16;
	localparam int CFG_W  = 16;

	// stream packing: position, weight, density from bit 0 up
	localparam int WGT_LSB   = POS_W;
	localparam int DEN_LSB   = POS_W + WGT_W;
	localparam int FIELDS_W  = POS_W + WGT_W + DEN_W;
	localparam int TDATA_W   = ((FIELDS_W + 7) / 8) * 8;
	localparam int PAD_W     = TDATA_W - FIELDS_W;
	localparam int TUSER_W   = 2;
	localparam int USR_ZERO  = 0;
	localparam int USR_CLR   = 1;

	// configuration register indexes
	localparam logic CFG_MAX_KEPT      = 1'b0;
	localparam logic CFG_DENSITY_FLOOR = 1'b1;

	// reset values of the configuration registers
	localparam logic [KEEP_W-1:0] MAX_KEPT_RST = 7'd5;
	localparam logic [FLR_W-1:0]  FLOOR_RST    = 16'd66;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PRUNE = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	// magnitude of a signed 32-bit word; the most negative value maps to 2^31
	function automatic logic [WGT_W-1:0] mag32(input logic [WGT_W-1:0] v);
		return v[WGT_W-1] ? (~v + 32'd1) : v;
	endfunction

endpackage

`default_nettype wire

FILE: sv/swt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module swt_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/sparse_weight_truncation_core.sv
// Top level of the sparse weight truncation core (top-k magnitude pruning).
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: position, weight, density
//  m_*      out  m_tvalid/m_tready  m_tdata: position, weight, density
//                                   m_tuser: was_zeroed, density_cleared; m_tlast
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// s_tready is high only while no vector is being judged. After the load of
// position NUM_VARS-1 a pruning vector is ranked: each stored weight is compared
// against the whole vector through the single read port of the weight RAM, one
// entry per cycle. Each of the NUM_VARS results then passes a RAM read and the
// output register, and waits while m_tready is low. The output register holds a
// result under stall. Reset clears control and configuration only; the RAM needs
// no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sparse_weight_truncation_core
	import swt_pkg::*;
#(
	parameter int NUM_VARS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input items
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // position, weight, density, zero pad
	// result items
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,  // out_position, out_weight, out_density, pad
	output logic      [TUSER_W-1:0] m_tuser,  // was_zeroed, density_cleared
	output logic                    m_tlast,
	// configuration writes
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_VARS - 1);
	localparam int RW = WGT_W + 1;

	state_t state_q;

	// configuration
	logic [KEEP_W-1:0] max_kept_q;
	logic [FLR_W-1:0]  floor_q;

	// held vector state
	logic [DEN_W-1:0] density_q;
	logic             cleared_q;
	logic             prune_q;

	// prune sweep control
	logic [AW-1:0] i_q, off_q, ptr_q;
	logic          wrap_q, issue_q;
	logic          v_s1, first_s1, last_s1, wrap_s1;
	logic [AW-1:0] i_s1;
	logic [WGT_W-1:0] wi_q, mi_q;
	logic             wi_nz_q;
	logic [AW-1:0]    cnt_q;

	// emit control
	logic [AW-1:0] e_q, e_s1;
	logic          rd_pend_q;

	// output register
	logic             m_tvalid_q;
	logic [POS_W-1:0] out_pos_q;
	logic [WGT_W-1:0] out_wgt_q;
	logic [DEN_W-1:0] out_den_q;
	logic             out_zero_q, out_clr_q, out_last_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	// input unpack
	logic [POS_W-1:0] in_pos;
	logic [WGT_W-1:0] in_wgt;
	logic [DEN_W-1:0] in_den;
	logic [AW-1:0]    in_addr;
	logic             in_range, accept, load, judge;
	logic             den_pos, den_low;

	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_wgt   = s_tdata[WGT_LSB +: WGT_W];
	assign in_den   = s_tdata[DEN_LSB +: DEN_W];
	assign in_addr  = in_pos[AW-1:0];
	assign in_range = {1'b0, in_pos} < (POS_W + 1)'(NUM_VARS);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load     = accept && in_range;
	assign judge    = load && (in_addr == LAST);

	// density check against the floor
	assign den_pos = !density_q[DEN_W-1] && (density_q != '0);
	assign den_low = density_q < {{(DEN_W-FLR_W){1'b0}}, floor_q};

	// ranking of the entry under the sweep against the held weight
	logic [WGT_W-1:0] rd_wgt, mj;
	logic             rd_mark, inc, drop, prune_wr;
	logic [AW-1:0]    cnt_next;

	assign rd_wgt   = ram_rdata[WGT_W-1:0];
	assign rd_mark  = ram_rdata[WGT_W];
	assign mj       = mag32(rd_wgt);
	assign inc      = v_s1 && !first_s1 && (rd_wgt != '0) &&
	                  ((mj > mi_q) || ((mj == mi_q) && !wrap_s1));
	assign cnt_next = cnt_q + AW'(inc);
	assign drop     = wi_nz_q && (8'(cnt_next) >= 8'(max_kept_q));
	assign prune_wr = v_s1 && last_s1;

	// emit read issue: only when the output register is free by the next cycle
	logic emit_issue;
	assign emit_issue = (state_q == ST_EMIT) && !rd_pend_q && (!m_tvalid_q || m_tready);

	// RAM port muxing
	always_comb begin
		ram_we    = load || prune_wr;
		ram_waddr = prune_wr ? i_s1 : in_addr;
		if (prune_wr) begin
			ram_wdata = drop ? {1'b1, WGT_W'(0)} : {1'b0, wi_q};
		end else begin
			ram_wdata = {1'b0, in_wgt};
		end
		ram_raddr = (state_q == ST_PRUNE) ? ptr_q : e_q;
	end

	swt_ram #(
		.WIDTH(RW),
		.DEPTH(NUM_VARS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_kept_q <= MAX_KEPT_RST;
			floor_q    <= FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_KEPT:      max_kept_q <= cfg_data[KEEP_W-1:0];
				CFG_DENSITY_FLOOR: floor_q    <= cfg_data[FLR_W-1:0];
				default: ;
			endcase
		end
	end

	// control: state, sweep counters, emit counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			density_q  <= '0;
			cleared_q  <= 1'b0;
			prune_q    <= 1'b0;
			i_q        <= '0;
			off_q      <= '0;
			ptr_q      <= '0;
			wrap_q     <= 1'b0;
			issue_q    <= 1'b0;
			v_s1       <= 1'b0;
			e_q        <= '0;
			rd_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a sweep read issued this cycle returns data next cycle
			v_s1 <= (state_q == ST_PRUNE) && issue_q;
			case (state_q)
				ST_IDLE: begin
					if (load && (in_addr == '0)) begin
						density_q <= in_den;
					end
					if (judge) begin
						i_q     <= '0;
						off_q   <= '0;
						ptr_q   <= '0;
						wrap_q  <= 1'b0;
						issue_q <= 1'b1;
						e_q     <= '0;
						if (den_pos && den_low) begin
							density_q <= '0;
							cleared_q <= 1'b1;
							prune_q   <= 1'b0;
							state_q   <= ST_EMIT;
						end else begin
							cleared_q <= 1'b0;
							prune_q   <= den_pos;
							state_q   <= den_pos ? ST_PRUNE : ST_EMIT;
						end
					end
				end
				ST_PRUNE: begin
					// issue one read per cycle, offset 0 is the entry being ranked
					if (issue_q) begin
						if (off_q == LAST) begin
							off_q <= '0;
							if (i_q == LAST) begin
								issue_q <= 1'b0;
							end else begin
								i_q    <= i_q + AW'(1);
								ptr_q  <= i_q + AW'(1);
								wrap_q <= 1'b0;
							end
						end else begin
							off_q <= off_q + AW'(1);
							if (ptr_q == LAST) begin
								ptr_q  <= '0;
								wrap_q <= 1'b1;
							end else begin
								ptr_q <= ptr_q + AW'(1);
							end
						end
					end
					// final write-back of the last entry ends the pass
					if (prune_wr && (i_s1 == LAST)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						if (e_q == LAST) begin
							state_q <= ST_IDLE;
						end else begin
							e_q <= e_q + AW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// read data of an emit read lands in the output register
			rd_pend_q <= emit_issue;
			if (rd_pend_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_PRUNE && issue_q) begin
			first_s1 <= (off_q == '0);
			last_s1  <= (off_q == LAST);
			wrap_s1  <= wrap_q;
			i_s1     <= i_q;
		end
		if (v_s1) begin
			if (first_s1) begin
				wi_q    <= rd_wgt;
				mi_q    <= mj;
				wi_nz_q <= (rd_wgt != '0);
				cnt_q   <= '0;
			end else begin
				cnt_q <= cnt_next;
			end
		end
		if (emit_issue) begin
			e_s1 <= e_q;
		end
		if (rd_pend_q) begin
			out_pos_q  <= POS_W'(e_s1);
			out_wgt_q  <= rd_wgt;
			out_den_q  <= density_q;
			out_zero_q <= rd_mark && prune_q;
			out_clr_q  <= cleared_q;
			out_last_q <= (e_s1 == LAST);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_den_q, out_wgt_q, out_pos_q};
	assign m_tuser  = {out_clr_q, out_zero_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: sv/swt_checker.sv
// Port-level checker for the sparse weight truncation core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swt_checker
	import swt_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic [TUSER_W-1:0] m_tuser
);

	// a stalled result stays offered and unchanged
	`ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

	// a pruned weight reads zero
	`ASSERT_IMPL(a_zeroed_is_zero, m_tvalid && m_tuser[USR_ZERO], m_tdata[WGT_LSB +: WGT_W] == '0)

	// a cleared density reads zero and never comes with pruning
	`ASSERT_IMPL(a_cleared_is_zero, m_tvalid && m_tuser[USR_CLR], m_tdata[DEN_LSB +: DEN_W] == '0)
	`ASSERT_IMPL(a_clear_no_prune, m_tvalid && m_tuser[USR_CLR], !m_tuser[USR_ZERO])

endmodule

bind sparse_weight_truncation_core swt_checker u_swt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

FILE: tb/sv/truncation_checker.sv
// Checker for the sparse weight truncation core: predicts each vector's results and compares them.
`timescale 1ns / 1ps

module truncation_checker
	import swt_pkg::*;
#(
	parameter int VEC_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // position, weight, density, pad
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,  // out_position, out_weight, out_density, pad
	input  logic [TUSER_W-1:0] m_tuser,  // was_zeroed, density_cleared
	input  logic               m_tlast,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output int                 fails,
	output int                 pending
);

	typedef struct {
		logic [POS_W-1:0] pos;
		logic [WGT_W-1:0] weight;
		logic [DEN_W-1:0] density;
		logic             zeroed;
		logic             cleared;
		logic             is_last;
	} weight_result_t;

	// predicted results, oldest first
	weight_result_t expected_weights[$];

	// private copy of the block's state and registers
	logic [WGT_W-1:0]  stored_w [VEC_LEN];
	logic [DEN_W-1:0]  vec_density;
	logic [KEEP_W-1:0] keep_limit;
	logic [FLR_W-1:0]  floor_level;
	int                mism_count = 0;

	// magnitude as 33 bits so the most negative weight ranks above all others
	function automatic logic [32:0] abs_weight(input logic [WGT_W-1:0] v);
		logic signed [32:0] wide;
		wide = $signed({v[WGT_W-1], v});
		return (wide < 0) ? -wide : wide;
	endfunction

	// floor check and top-k pruning once the last position is loaded
	task automatic judge_vector();
		logic           zmark [VEC_LEN];
		logic           clr;
		logic [32:0]    least;
		int             pick;
		int             live;
		longint         dens;
		weight_result_t r;
		clr = 1'b0;
		for (int i = 0; i < VEC_LEN; i++)
			zmark[i] = 1'b0;
		dens = longint'($signed(vec_density));
		if (dens > 0 && dens < longint'(floor_level)) begin
			vec_density = '0;
			clr = 1'b1;
		end else if (dens > 0) begin
			live = 0;
			for (int i = 0; i < VEC_LEN; i++)
				if (stored_w[i] != '0)
					live++;
			// drop the smallest nonzero magnitude, lowest position on ties
			while (live > int'(keep_limit)) begin
				pick = -1;
				least = '0;
				for (int i = 0; i < VEC_LEN; i++) begin
					if (stored_w[i] != '0 && (pick < 0 || abs_weight(stored_w[i]) < least)) begin
						pick = i;
						least = abs_weight(stored_w[i]);
					end
				end
				stored_w[pick] = '0;
				zmark[pick] = 1'b1;
				live--;
			end
		end
		for (int i = 0; i < VEC_LEN; i++) begin
			r.pos = POS_W'(i);
			r.weight = stored_w[i];
			r.density = vec_density;
			r.zeroed = zmark[i];
			r.cleared = clr;
			r.is_last = (i == VEC_LEN - 1);
			expected_weights.push_back(r);
		end
	endtask

	// store one accepted load; out-of-range positions are dropped
	task automatic take_load(input logic [TDATA_W-1:0] d);
		logic [POS_W-1:0] p;
		p = d[POS_W-1:0];
		if (p < VEC_LEN) begin
			stored_w[p] = d[WGT_LSB +: WGT_W];
			if (p == 0)
				vec_density = d[DEN_LSB +: DEN_W];
			if (p == VEC_LEN - 1)
				judge_vector();
		end
	endtask

	// compare one emitted item against the oldest prediction
	task automatic check_result();
		weight_result_t   want;
		logic [POS_W-1:0] got_pos;
		logic [WGT_W-1:0] got_w;
		logic [DEN_W-1:0] got_d;
		got_pos = m_tdata[POS_W-1:0];
		got_w = m_tdata[WGT_LSB +: WGT_W];
		got_d = m_tdata[DEN_LSB +: DEN_W];
		if (expected_weights.size() == 0) begin
			mism_count++;
			if (mism_count <= 10)
				$display("%0t: unexpected result: pos=%0d w=%h d=%h z=%b c=%b l=%b", $realtime,
					got_pos, got_w, got_d, m_tuser[USR_ZERO], m_tuser[USR_CLR], m_tlast);
		end else begin
			want = expected_weights.pop_front();
			if (got_pos !== want.pos || got_w !== want.weight || got_d !== want.density ||
					m_tuser[USR_ZERO] !== want.zeroed || m_tuser[USR_CLR] !== want.cleared ||
					m_tlast !== want.is_last) begin
				mism_count++;
				if (mism_count <= 10) begin
					$display("%0t: mismatch, expected pos=%0d w=%h d=%h z=%b c=%b l=%b", $realtime,
						want.pos, want.weight, want.density, want.zeroed, want.cleared,
						want.is_last);
					$display("%0t:           got      pos=%0d w=%h d=%h z=%b c=%b l=%b", $realtime,
						got_pos, got_w, got_d, m_tuser[USR_ZERO], m_tuser[USR_CLR], m_tlast);
				end
			end
		end
	endtask

	// watch the three ports at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_weights.delete();
			keep_limit = MAX_KEPT_RST;
			floor_level = FLOOR_RST;
			vec_density = '0;
			for (int i = 0; i < VEC_LEN; i++)
				stored_w[i] = '0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_KEPT)
					keep_limit = cfg_data[KEEP_W-1:0];
				else
					floor_level = cfg_data[FLR_W-1:0];
			end
			if (s_tvalid && s_tready)
				take_load(s_tdata);
		end
		fails <= mism_count;
		pending <= expected_weights.size();
	end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the sparse weight truncation core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
	import swt_pkg::*;

	localparam int VEC_LEN      = 32;
	localparam int RANDOM_ITEMS = 140;
	localparam int SETTLE       = VEC_LEN;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0] m_tuser;
	logic               m_tlast;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_MAX_KEPT;
	logic [CFG_W-1:0]   cfg_data = '0;
	int                 check_fails;
	int                 check_pending;

	// sender and receiver pacing
	int                 burst_left = 0;
	bit                 tx_steady = 1'b0;
	bit                 rx_steady = 1'b0;
	int                 rx_run = 0;
	logic               rx_level = 1'b1;

	logic [FLR_W-1:0]   cur_floor = FLOOR_RST;
	int                 random_loads = 0;

	sparse_weight_truncation_core #(.NUM_VARS(VEC_LEN)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	truncation_checker #(.VEC_LEN(VEC_LEN)) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.fails    (check_fails),
		.pending  (check_pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: runs of ready and stall, or steady ready in some phases
	always @(posedge clk) begin
		if (rx_run > 0) begin
			rx_run--;
		end else if (rx_steady) begin
			rx_level = 1'b1;
			rx_run = 16;
		end else begin
			rx_level = ($urandom_range(0, 2) != 0);
			rx_run = rx_level ? $urandom_range(0, 24) : $urandom_range(0, 6);
		end
		m_tready <= rx_level;
	end

	// one load, sent in bursts with random gaps between them
	task automatic load_weight(input int pos, input logic [31:0] w, input logic [31:0] d);
		int gap;
		if (!tx_steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_W{1'b0}}, d, w, POS_W'(pos)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// both registers back to back, only while idle
	task automatic write_regs(input logic [CFG_W-1:0] keep_word, input logic [FLR_W-1:0] flr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_KEPT;
		cfg_data <= keep_word;
		@(posedge clk);
		cfg_index <= CFG_DENSITY_FLOOR;
		cfg_data <= flr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop sending and wait for every predicted result
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (check_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// zeros, small magnitudes for ties, extremes and full-range values
	function automatic logic [31:0] pick_weight();
		int          r;
		logic [31:0] m;
		r = $urandom_range(0, 19);
		m = $urandom_range(1, 4);
		case (r)
			0, 1, 2:       return '0;
			3, 4, 5, 6, 7: return $urandom_range(0, 1) ? m : -m;
			8:             return 32'h8000_0000;
			9:             return 32'h7FFF_FFFF;
			10:            return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
			default:       return $urandom;
		endcase
	endfunction

	// density around the current floor, plus zero, negative and extremes
	function automatic logic [31:0] pick_density();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return '0;
			1:       return {1'b1, 31'($urandom)};
			2:       return (cur_floor > 1) ? 32'($urandom_range(1, cur_floor - 1)) : 32'd1;
			3:       return {16'b0, cur_floor};
			4:       return 32'h7FFF_FFFF;
			5:       return 32'h8000_0000;
			default: return {1'b0, 31'($urandom)};
		endcase
	endfunction

	// mostly full ordered vectors; some sparse shuffled ones with stray positions
	task automatic random_vector();
		int order[$];
		int tmp;
		int j;
		int kind;
		kind = $urandom_range(0, 3);
		for (int p = 0; p < VEC_LEN - 1; p++)
			if (kind != 3 || $urandom_range(0, 1))
				order.push_back(p);
		if (kind == 3) begin
			for (int i = order.size() - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		order.push_back(VEC_LEN - 1);
		foreach (order[i]) begin
			if (kind == 3 && $urandom_range(0, 5) == 0)
				load_weight($urandom_range(VEC_LEN, 63), $urandom, $urandom);
			load_weight(order[i], pick_weight(), (order[i] == 0) ? pick_density() : $urandom);
			random_loads++;
		end
	endtask

	initial begin
		int               phase;
		logic [31:0]      w;
		logic [CFG_W-1:0] keep_word;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// first vector fills every entry; density right at the floor, ties and extremes
		for (int p = 0; p < VEC_LEN; p++) begin
			case (p)
				0:       w = 32'h8000_0000;
				1:       w = 32'h7FFF_FFFF;
				2:       w = 32'h0000_0000;
				3:       w = 32'h0000_0001;
				4:       w = 32'hFFFF_FFFF;
				default: w = (p % 4 == 0) ? 32'd0 : ((p % 2 == 1) ? 32'd3 : 32'hFFFF_FFFD);
			endcase
			load_weight(p, w, (p == 0) ? {16'b0, FLOOR_RST} : $urandom);
		end
		// one below the floor: density cleared, weights pass
		load_weight(0, 32'h0000_1234, {16'b0, FLOOR_RST} - 32'd1);
		load_weight(VEC_LEN - 1, 32'hFFFF_0000, $urandom);
		// smallest positive density
		load_weight(0, 32'h8000_0000, 32'd1);
		load_weight(VEC_LEN - 1, 32'd7, $urandom);
		// cleared density is held; a lone last position sees zero
		load_weight(VEC_LEN - 1, 32'd9, $urandom);
		// most negative density leaves the vector alone
		load_weight(0, 32'd5, 32'h8000_0000);
		load_weight(VEC_LEN - 1, 32'hFFFF_FFFB, $urandom);
		// zero density
		load_weight(0, 32'd0, 32'd0);
		load_weight(5, 32'd5, $urandom);
		load_weight(VEC_LEN - 1, 32'd0, $urandom);
		// largest density; stray positions are dropped
		load_weight(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		load_weight(VEC_LEN, $urandom, $urandom);
		load_weight(63, $urandom, $urandom);
		load_weight(VEC_LEN - 1, 32'h8000_0000, $urandom);
		// no position 0: held density applies again, stale entries reused
		load_weight(3, 32'd3, $urandom);
		load_weight(VEC_LEN - 1, 32'hFFFF_FFFD, $urandom);
		settle();

		// random phases, each under new register settings
		phase = 0;
		while (random_loads < RANDOM_ITEMS) begin
			case (phase)
				0: begin
					keep_word = 16'd0;
					cur_floor = 16'd0;
				end
				1: begin
					// limit 127 with the unused upper bits set
					keep_word = 16'hFFFF;
					cur_floor = 16'hFFFF;
				end
				2: begin
					keep_word = 16'd1;
					cur_floor = 16'hFFFF;
				end
				3: begin
					keep_word = CFG_W'(VEC_LEN);
					cur_floor = FLR_W'($urandom);
				end
				4: begin
					keep_word = CFG_W'(VEC_LEN - 1);
					cur_floor = FLR_W'($urandom_range(0, 300));
				end
				default: begin
					keep_word = CFG_W'($urandom_range(0, 127));
					cur_floor = FLR_W'($urandom);
				end
			endcase
			write_regs(keep_word, cur_floor);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 2)) random_vector();
			settle();
			phase++;
		end

		if (check_fails == 0 && check_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sparse_weight_truncation_core.f
+incdir+sv
sv/swt_pkg.sv
sv/swt_ram.sv
sv/sparse_weight_truncation_core.sv
sv/swt_checker.sv
tb/sv/truncation_checker.sv
tb/sv/tb.sv
